// File: src/mec_pkg.sv
// shared types and constants for the mandelbrot escape counter
`default_nettype none

package mec_pkg;

  // default point format: signed Q4.28
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 28;

  // iteration count and limit register
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

  // intermediate products are carried as 64-bit signed values
  localparam int ACC_W = 64;
  localparam int MAG_W = 62;
  localparam logic [MAG_W-1:0] SQ_CAP = {MAG_W{1'b1}};

  // operation issued to the shared multiplier
  typedef enum logic [1:0] {
    MUL_SQ_RE,
    MUL_SQ_IM,
    MUL_CROSS
  } mul_op_t;

  // iteration sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_CHECK,
    ST_DONE
  } state_t;

  // finished count handed from the core to the output stage
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } core_result_t;

endpackage

`default_nettype wire

// File: src/mandelbrot_escape_count.sv
// top level: stream ports, limit register and output register
//
// Usage: one point c per slave transaction, c_real in the low DATA_WIDTH
// bits of s_axis_tdata and c_imag above it, both signed with FRAC_BITS
// fraction bits. Each point gives one master transaction carrying its
// escape-time count in m_axis_tdata.
// The limit register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce it.
// One shared multiplier serves re^2, im^2 and 2*re*im in turn, through the
// states SQ_RE, SQ_IM and CROSS, then CHECK, for each iteration.
// s_axis_tready is high only while the sequencer is idle and out of reset,
// so one point is in work at a time; the next point can be accepted only
// after the result of the previous one has left the core.
// Reset clears the sequencer and output valid and sets the limit to 256.
// When the receiver stalls the count waits in the output register; a
// further point may be accepted meanwhile and its result waits in the
// core until the output register is free.
`default_nettype none

module mandelbrot_escape_count #(
  parameter int DATA_WIDTH = mec_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst,
  // slave channel
  input  wire                                         s_axis_tvalid,
  output logic                                        s_axis_tready,
  // tdata fields from bit 0: c_real, c_imag, zero fill
  input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // master channel
  output logic                                        m_axis_tvalid,
  input  wire                                         m_axis_tready,
  // tdata fields from bit 0: iteration_count
  output logic [mec_pkg::COUNT_W-1:0]                 m_axis_tdata,
  // configuration
  input  wire                                         cfg_we,
  input  wire logic [mec_pkg::COUNT_W-1:0]            cfg_wdata
);

  logic [mec_pkg::COUNT_W-1:0] max_iterations;
  logic                        core_idle;
  logic                        out_free;
  mec_pkg::core_result_t       core_res;

  // iteration limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mec_pkg::MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iterations <= cfg_wdata;
    end
  end

  assign s_axis_tready = core_idle && !rst;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  mec_core #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (s_axis_tvalid),
    .c_real        ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
    .c_imag        ($signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
    .max_iterations(max_iterations),
    .idle          (core_idle),
    .res           (core_res),
    .res_ready     (out_free)
  );

  // output register toward the master channel
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && core_res.valid) begin
      m_axis_tdata <= core_res.count;
    end
  end

endmodule

`default_nettype wire

// File: src/mec_mul_unit.sv
// shared multiplier with floor shift and magnitude saturation
`default_nettype none

module mec_mul_unit #(
  parameter int DATA_WIDTH = mec_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire logic signed [DATA_WIDTH-1:0]   z_re,
  input  wire logic signed [DATA_WIDTH-1:0]   z_im,
  input  wire mec_pkg::mul_op_t               op,
  output logic signed [mec_pkg::ACC_W-1:0]    result
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int QW = (PW + 1 > mec_pkg::MAG_W + 1) ? PW + 1 : mec_pkg::MAG_W + 1;

  logic signed [DATA_WIDTH-1:0] op_a;
  logic signed [DATA_WIDTH-1:0] op_b;
  logic [DATA_WIDTH-1:0]        mag_a;
  logic [DATA_WIDTH-1:0]        mag_b;

  // registered product
  logic [PW-1:0] prod;
  logic          prod_neg;
  logic          prod_cross;

  logic [PW-1:0]             q_full;
  logic [PW-1:0]             q_cross;
  logic                      rem_full;
  logic                      rem_cross;
  logic [QW-1:0]             q_ext;
  logic                      rnd;
  logic [mec_pkg::MAG_W-1:0] mag;

  // operand select: re*re, im*im or re*im
  always_comb begin
    op_a = (op == mec_pkg::MUL_SQ_IM) ? z_im : z_re;
    op_b = (op == mec_pkg::MUL_SQ_RE) ? z_re : z_im;
    mag_a = op_a[DATA_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    mag_b = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;
  end

  // unsigned magnitude multiply, sign kept aside
  always_ff @(posedge clk) begin
    prod       <= PW'(mag_a) * PW'(mag_b);
    prod_neg   <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
    prod_cross <= (op == mec_pkg::MUL_CROSS);
  end

  // floor shift: squares by FRAC_BITS, cross term by one less (times two)
  always_comb begin
    q_full    = prod >> FRAC_BITS;
    q_cross   = prod >> (FRAC_BITS - 1);
    rem_full  = |prod[FRAC_BITS-1:0];
    rem_cross = |prod[FRAC_BITS-2:0];
    rnd       = prod_neg & (prod_cross ? rem_cross : rem_full);
    q_ext     = QW'(prod_cross ? q_cross : q_full) + QW'(rnd);
    mag       = (q_ext > QW'(mec_pkg::SQ_CAP)) ? mec_pkg::SQ_CAP : q_ext[mec_pkg::MAG_W-1:0];
    result    = prod_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  end

endmodule

`default_nettype wire

// File: src/mec_core.sv
// iteration sequencer and z registers around the shared multiplier
`default_nettype none

module mec_core #(
  parameter int DATA_WIDTH = mec_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire logic signed [DATA_WIDTH-1:0]    c_real,
  input  wire logic signed [DATA_WIDTH-1:0]    c_imag,
  input  wire logic [mec_pkg::COUNT_W-1:0]     max_iterations,
  output logic                                 idle,
  output mec_pkg::core_result_t                res,
  input  wire                                  res_ready
);

  localparam int AW = mec_pkg::ACC_W;
  localparam int SW = mec_pkg::MAG_W + 1;
  localparam logic signed [AW-1:0] ZMAX = (AW'(1) <<< (DATA_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] ZMIN = -ZMAX - AW'(1);
  localparam logic [SW-1:0] FOUR = SW'(4) << FRAC_BITS;

  mec_pkg::state_t state;
  mec_pkg::state_t state_next;

  logic signed [DATA_WIDTH-1:0]  c_re;
  logic signed [DATA_WIDTH-1:0]  c_im;
  logic signed [DATA_WIDTH-1:0]  z_re;
  logic signed [DATA_WIDTH-1:0]  z_im;
  logic signed [AW-1:0]          d_re;
  logic signed [AW-1:0]          d_im;
  logic [mec_pkg::COUNT_W-1:0]   count;
  logic [mec_pkg::COUNT_W-1:0]   limit;

  mec_pkg::mul_op_t     op;
  logic signed [AW-1:0] mul_res;
  logic                 cap_d_re;
  logic                 cap_d_im;
  logic                 do_step;
  logic [SW-1:0]        mag_sum;
  logic signed [AW-1:0] re_sum;
  logic signed [AW-1:0] im_sum;
  logic signed [DATA_WIDTH-1:0] z_re_next;
  logic signed [DATA_WIDTH-1:0] z_im_next;

  mec_mul_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .z_re  (z_re),
    .z_im  (z_im),
    .op    (op),
    .result(mul_res)
  );

  // escape test and the next z from the finished products
  always_comb begin
    mag_sum = {1'b0, d_re[mec_pkg::MAG_W-1:0]} + {1'b0, d_im[mec_pkg::MAG_W-1:0]};
    re_sum  = d_re - d_im + AW'(c_re);
    im_sum  = mul_res + AW'(c_im);
    if (re_sum > ZMAX) begin
      z_re_next = DATA_WIDTH'(ZMAX);
    end else if (re_sum < ZMIN) begin
      z_re_next = DATA_WIDTH'(ZMIN);
    end else begin
      z_re_next = DATA_WIDTH'(re_sum);
    end
    if (im_sum > ZMAX) begin
      z_im_next = DATA_WIDTH'(ZMAX);
    end else if (im_sum < ZMIN) begin
      z_im_next = DATA_WIDTH'(ZMIN);
    end else begin
      z_im_next = DATA_WIDTH'(im_sum);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next = state;
    op         = mec_pkg::MUL_SQ_RE;
    cap_d_re   = 1'b0;
    cap_d_im   = 1'b0;
    do_step    = 1'b0;
    idle       = 1'b0;
    res.valid  = 1'b0;
    res.count  = count;
    case (state)
      mec_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_next = mec_pkg::ST_SQ_RE;
        end
      end
      mec_pkg::ST_SQ_RE: begin
        op         = mec_pkg::MUL_SQ_RE;
        state_next = mec_pkg::ST_SQ_IM;
      end
      mec_pkg::ST_SQ_IM: begin
        op         = mec_pkg::MUL_SQ_IM;
        cap_d_re   = 1'b1;
        state_next = mec_pkg::ST_CROSS;
      end
      mec_pkg::ST_CROSS: begin
        op         = mec_pkg::MUL_CROSS;
        cap_d_im   = 1'b1;
        state_next = mec_pkg::ST_CHECK;
      end
      mec_pkg::ST_CHECK: begin
        if ((count < limit) && (mag_sum <= FOUR)) begin
          do_step    = 1'b1;
          state_next = mec_pkg::ST_SQ_RE;
        end else begin
          state_next = mec_pkg::ST_DONE;
        end
      end
      mec_pkg::ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = mec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mec_pkg::ST_IDLE;
      end
    endcase
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (idle && start) begin
      c_re  <= c_real;
      c_im  <= c_imag;
      z_re  <= c_real;
      z_im  <= c_imag;
      count <= '0;
      limit <= (max_iterations == '0) ? '0 : max_iterations - 1'b1;
    end
    if (cap_d_re) begin
      d_re <= mul_res;
    end
    if (cap_d_im) begin
      d_im <= mul_res;
    end
    if (do_step) begin
      z_re  <= z_re_next;
      z_im  <= z_im_next;
      count <= count + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the mandelbrot escape counter: directed table, random phases
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINT_W = mec_pkg::DATA_WIDTH_DEF;
  localparam int FRAC = mec_pkg::FRAC_BITS_DEF;
  localparam int CNT_W = mec_pkg::COUNT_W;
  localparam int PREDICT = -1;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int QUIET_LIMIT = 1200000;
  localparam int LONG_HOLD_CYCLES = 400;

  // fixed-point bounds used by the escape-time predictor
  localparam logic signed [127:0] PROD_CAP = 128'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ESCAPE_BOUND = 64'sh4000_0000;
  localparam logic signed [63:0] PT_MAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] PT_MIN = -64'sh8000_0000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [CNT_W-1:0]   lim;
    logic [POINT_W-1:0] re;
    logic [POINT_W-1:0] im;
    int                 want;
  } point_row_t;

  typedef struct packed {
    logic [CNT_W-1:0] lim;
    int               points;
    idle_mode_t       mode;
    logic             long_hold;
  } rand_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // fields from bit 0: c_real, c_imag
  logic [2*POINT_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // fields from bit 0: iteration_count
  logic [CNT_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // bench copy of the limit register and pending counts
  logic [CNT_W-1:0] limit_shadow = 16'd256;
  logic [CNT_W-1:0] pending_counts [$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic hold_go = 1'b0;

  int errors = 0;
  int quiet_cycles = 0;
  int points_sent = 0;
  int counts_checked = 0;
  int limit_hits = 0;
  int escapes = 0;
  int limit_writes = 0;

  // directed points: extremes, fixed points, cycles, limit corner cases
  point_row_t dir_rows [23] = '{
    '{16'd256,   32'h0000_0000, 32'h0000_0000, 255},
    '{16'd256,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
    '{16'd256,   32'h8000_0000, 32'h8000_0000, 0},
    '{16'd256,   32'h8000_0000, 32'h7FFF_FFFF, 0},
    '{16'd256,   32'h7FFF_FFFF, 32'h8000_0000, 0},
    '{16'd256,   32'h2000_0000, 32'h0000_0000, PREDICT},
    '{16'd256,   32'hE000_0000, 32'h0000_0000, PREDICT},
    '{16'd256,   32'h0000_0000, 32'h1000_0000, PREDICT},
    '{16'd256,   32'hF000_0000, 32'h0000_0000, PREDICT},
    '{16'd256,   32'h0400_0000, 32'h0000_0000, PREDICT},
    '{16'd256,   32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICT},
    '{16'd256,   32'hAAAA_AAAA, 32'h5555_5555, 0},
    '{16'd256,   32'h5555_5555, 32'hAAAA_AAAA, 0},
    '{16'd256,   32'hF400_0000, 32'h0199_999A, PREDICT},
    '{16'd1,     32'h0000_0000, 32'h0000_0000, 0},
    '{16'd1,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
    '{16'd0,     32'h0000_0000, 32'h0000_0000, 0},
    '{16'd2,     32'h0000_0000, 32'h0000_0000, 1},
    '{16'd2,     32'h2000_0000, 32'h0000_0000, 1},
    '{16'd65535, 32'h0000_0000, 32'h0000_0000, 65534},
    '{16'd65535, 32'h7FFF_FFFF, 32'h8000_0000, 0},
    '{16'd65535, 32'h04CC_CCCD, 32'h0000_0000, PREDICT},
    '{16'd256,   32'h0800_0000, 32'h0800_0000, PREDICT}
  };

  // random phases: limit, point count, idling, long receiver hold
  rand_phase_t rand_phases [8] = '{
    '{16'd16,   300, IDLE_NONE, 1'b0},
    '{16'd16,   250, IDLE_SEND, 1'b0},
    '{16'd3,    250, IDLE_RECV, 1'b1},
    '{16'd64,   250, IDLE_BOTH, 1'b0},
    '{16'd256,  200, IDLE_NONE, 1'b0},
    '{16'd1,    100, IDLE_BOTH, 1'b0},
    '{16'd1000,  40, IDLE_SEND, 1'b0},
    '{16'd100,  360, IDLE_RECV, 1'b0}
  };

  mandelbrot_escape_count dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_pct(idle_mode_t mode);
    case (mode)
      IDLE_SEND: return 69;
      IDLE_BOTH: return 37;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct(idle_mode_t mode);
    case (mode)
      IDLE_RECV: return 69;
      IDLE_BOTH: return 37;
      default: return 0;
    endcase
  endfunction

  // floor(a*b / 2^sh) with magnitude clamped to 2^62 - 1
  function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                        logic signed [63:0] b, int sh);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] q;
    wa = a;
    wb = b;
    q = (wa * wb) >>> sh;
    if (q > PROD_CAP) q = PROD_CAP;
    else if (q < -PROD_CAP) q = -PROD_CAP;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_point(logic signed [63:0] v);
    if (v > PT_MAX) return PT_MAX;
    if (v < PT_MIN) return PT_MIN;
    return v;
  endfunction

  // escape-time count for one point, z starting at c
  function automatic logic [CNT_W-1:0] escape_steps(logic [POINT_W-1:0] re_bits,
                                                    logic [POINT_W-1:0] im_bits,
                                                    logic [CNT_W-1:0] lim);
    logic signed [63:0] c_re;
    logic signed [63:0] c_im;
    logic signed [63:0] z_re;
    logic signed [63:0] z_im;
    logic signed [63:0] sq_re;
    logic signed [63:0] sq_im;
    logic signed [63:0] twice_re_im;
    logic [CNT_W-1:0] steps;
    logic [CNT_W-1:0] top;
    c_re = {{(64-POINT_W){re_bits[POINT_W-1]}}, re_bits};
    c_im = {{(64-POINT_W){im_bits[POINT_W-1]}}, im_bits};
    z_re = c_re;
    z_im = c_im;
    sq_re = scaled_product(z_re, z_re, FRAC);
    sq_im = scaled_product(z_im, z_im, FRAC);
    top = (lim == '0) ? '0 : lim - 1'b1;
    steps = '0;
    while (steps < top && (sq_re + sq_im) <= ESCAPE_BOUND) begin
      twice_re_im = scaled_product(z_re, z_im, FRAC - 1);
      z_im = clamp_point(twice_re_im + c_im);
      z_re = clamp_point(sq_re - sq_im + c_re);
      sq_re = scaled_product(z_re, z_re, FRAC);
      sq_im = scaled_product(z_im, z_im, FRAC);
      steps++;
    end
    return steps;
  endfunction

  // mostly points near the set, the rest any bit pattern
  function automatic void pick_point(output logic [POINT_W-1:0] re,
                                     output logic [POINT_W-1:0] im);
    if ($urandom_range(99) < 75) begin
      re = $urandom_range(697932185) - 32'd536870912;
      im = $urandom_range(671088640) - 32'd335544320;
    end else begin
      re = $urandom();
      im = $urandom();
    end
  endfunction

  // offer one point, record its expected count on acceptance; entered at a falling edge
  task automatic send_point(logic [POINT_W-1:0] re, logic [POINT_W-1:0] im, int want);
    logic [CNT_W-1:0] predicted;
    logic [CNT_W-1:0] top;
    while ($urandom_range(99) < gap_pct(idle_mode)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {im, re};
    do @(posedge clk); while (!s_axis_tready);
    predicted = escape_steps(re, im, limit_shadow);
    if (want == PREDICT) pending_counts.push_back(predicted);
    else pending_counts.push_back(want[CNT_W-1:0]);
    top = (limit_shadow == '0) ? '0 : limit_shadow - 1'b1;
    if (predicted == top) limit_hits++;
    else escapes++;
    points_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every count is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_shadow = value;
    limit_writes++;
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    static int hold_left = 0;
    static bit hold_taken = 1'b0;
    if (hold_go && !hold_taken) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct(idle_mode));
    end
  end

  // compare each result transaction with the oldest pending count
  always @(posedge clk) begin
    logic [CNT_W-1:0] want_count;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        errors++;
        if (errors <= SHOWN_MISMATCHES)
          $display("unexpected result transaction: count %0d", m_axis_tdata);
      end else begin
        want_count = pending_counts.pop_front();
        if (m_axis_tdata !== want_count) begin
          errors++;
          if (errors <= SHOWN_MISMATCHES)
            $display("count mismatch at result %0d: expected %0d, got %0d",
                     counts_checked, want_count, m_axis_tdata);
        end
      end
      counts_checked++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [POINT_W-1:0] re;
    logic [POINT_W-1:0] im;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].lim != limit_shadow) begin
        drain();
        write_limit(dir_rows[r].lim);
      end
      send_point(dir_rows[r].re, dir_rows[r].im, dir_rows[r].want);
    end
    drain();

    // random phases, limit and idling changed only while idle
    foreach (rand_phases[p]) begin
      write_limit(rand_phases[p].lim);
      idle_mode = rand_phases[p].mode;
      if (rand_phases[p].long_hold) hold_go = 1'b1;
      repeat (rand_phases[p].points) begin
        pick_point(re, im);
        send_point(re, im, PREDICT);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d points over %0d limit writes (limits 0 to 65535)",
             points_sent, limit_writes);
    $display("%0d counts checked: %0d escaped, %0d ran to the limit, %0d errors",
             counts_checked, escapes, limit_hits, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
